// ===== design/apme_pkg.sv =====
package apme_pkg;

  // number formats
  localparam int COEF_FRAC_BITS = 16;
  localparam int COEF_WIDTH     = 20;
  localparam int SAMPLE_W       = 16;
  localparam int Y_W            = 18;
  localparam int OPB_W          = Y_W + 1;
  localparam int PROD_W         = COEF_WIDTH + OPB_W;
  localparam int BQ_W           = PROD_W + 3;
  localparam int MIX_W          = OPB_W + COEF_FRAC_BITS;
  localparam int ACC_W          = ((BQ_W > MIX_W) ? BQ_W : MIX_W) + 1;

  // saturation limits
  localparam int Y_MAX   = 2 ** (Y_W - 1) - 1;
  localparam int Y_MIN   = -(2 ** (Y_W - 1));
  localparam int OUT_MAX = 2 ** (SAMPLE_W - 1) - 1;
  localparam int OUT_MIN = -(2 ** (SAMPLE_W - 1));

  // register map
  localparam int NUM_REGS  = 6;
  localparam int REG_IDX_W = 3;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_COEF_X0,
    REG_COEF_X1,
    REG_COEF_X2,
    REG_COEF_Y1,
    REG_COEF_Y2,
    REG_MIX_GAIN
  } reg_idx_t;

  typedef logic signed [COEF_WIDTH-1:0] coef_t;
  typedef coef_t coef_bank_t [NUM_REGS];

  localparam coef_t MIX_GAIN_RESET = COEF_WIDTH'(2 ** (COEF_FRAC_BITS - 1));

  // multiplier second operand
  typedef enum logic [2:0] {
    OPB_X,
    OPB_D1,
    OPB_D2,
    OPB_FD1,
    OPB_FD2,
    OPB_DIFF
  } opb_sel_t;

  // accumulator operation
  typedef enum logic [2:0] {
    ACC_HOLD,
    ACC_PROD,
    ACC_ADD,
    ACC_SUB,
    ACC_MIX
  } acc_op_t;

  // sequencer branch condition
  typedef enum logic [1:0] {
    JMP_NEXT,
    JMP_WAIT_IN,
    JMP_WAIT_OUT
  } jump_t;

  localparam int NUM_STEPS = 11;
  localparam int STEP_W    = $clog2(NUM_STEPS);

  typedef logic [STEP_W-1:0] step_t;

  // one control word per step
  typedef struct packed {
    reg_idx_t coef_sel;
    opb_sel_t opb_sel;
    acc_op_t  acc_op;
    logic     y_load;
    jump_t    jump;
    step_t    next_step;
  } ctrl_t;

  // microprogram: six products on one multiplier, then saturate and mix
  localparam ctrl_t PROGRAM [NUM_STEPS] = '{
    '{REG_COEF_X0,  OPB_X,    ACC_HOLD, 1'b0, JMP_WAIT_IN,  step_t'(1)},
    '{REG_COEF_X0,  OPB_X,    ACC_HOLD, 1'b0, JMP_NEXT,     step_t'(2)},
    '{REG_COEF_X1,  OPB_D1,   ACC_PROD, 1'b0, JMP_NEXT,     step_t'(3)},
    '{REG_COEF_X2,  OPB_D2,   ACC_ADD,  1'b0, JMP_NEXT,     step_t'(4)},
    '{REG_COEF_Y1,  OPB_FD1,  ACC_ADD,  1'b0, JMP_NEXT,     step_t'(5)},
    '{REG_COEF_Y2,  OPB_FD2,  ACC_SUB,  1'b0, JMP_NEXT,     step_t'(6)},
    '{REG_COEF_Y2,  OPB_FD2,  ACC_SUB,  1'b0, JMP_NEXT,     step_t'(7)},
    '{REG_MIX_GAIN, OPB_DIFF, ACC_HOLD, 1'b1, JMP_NEXT,     step_t'(8)},
    '{REG_MIX_GAIN, OPB_DIFF, ACC_MIX,  1'b0, JMP_NEXT,     step_t'(9)},
    '{REG_MIX_GAIN, OPB_DIFF, ACC_ADD,  1'b0, JMP_NEXT,     step_t'(10)},
    '{REG_MIX_GAIN, OPB_DIFF, ACC_HOLD, 1'b0, JMP_WAIT_OUT, step_t'(0)}
  };

endpackage

// ===== design/apme_datapath.sv =====
module apme_datapath (
  input  logic                                   clk,
  input  logic                                   rst,
  input  apme_pkg::ctrl_t                        ctrl,
  input  apme_pkg::coef_bank_t                   coefs,
  input  logic                                   load_x,
  input  logic signed [apme_pkg::SAMPLE_W-1:0]   left_sample,
  input  logic signed [apme_pkg::SAMPLE_W-1:0]   right_sample,
  output logic signed [apme_pkg::SAMPLE_W-1:0]   out_sample,
  output logic                                   clipped
);

  localparam int AW = apme_pkg::ACC_W;
  localparam int SW = apme_pkg::SAMPLE_W;
  localparam int YW = apme_pkg::Y_W;
  localparam int BW = apme_pkg::OPB_W;

  localparam logic signed [AW-1:0] RND_BIAS = AW'(2 ** apme_pkg::COEF_FRAC_BITS - 1);
  localparam logic signed [AW-1:0] Y_HI     = AW'(apme_pkg::Y_MAX);
  localparam logic signed [AW-1:0] Y_LO     = AW'(apme_pkg::Y_MIN);
  localparam logic signed [AW-1:0] O_HI     = AW'(apme_pkg::OUT_MAX);
  localparam logic signed [AW-1:0] O_LO     = AW'(apme_pkg::OUT_MIN);

  logic signed [SW-1:0]                 x;
  logic signed [SW-1:0]                 d1;
  logic signed [SW-1:0]                 d2;
  logic signed [YW-1:0]                 fd1;
  logic signed [YW-1:0]                 fd2;
  logic signed [YW-1:0]                 y;
  logic signed [apme_pkg::PROD_W-1:0]   prod;
  logic signed [AW-1:0]                 acc;

  logic signed [SW:0]                   lr_sum;
  logic signed [BW-1:0]                 xy_sum;
  logic signed [BW-1:0]                 xy_diff;
  logic signed [BW-1:0]                 opb;
  logic signed [AW-1:0]                 acc_shr;
  logic signed [YW-1:0]                 y_sat;

  // divide by 2^frac, rounding toward zero
  function automatic logic signed [AW-1:0] trunc_shift(input logic signed [AW-1:0] v);
    logic signed [AW-1:0] t;
    t = v + (v[AW-1] ? RND_BIAS : '0);
    return t >>> apme_pkg::COEF_FRAC_BITS;
  endfunction

  // mono average, floor of half the sum
  assign lr_sum = (SW+1)'(left_sample) + (SW+1)'(right_sample);

  assign xy_sum  = BW'(x) + BW'(y);
  assign xy_diff = BW'(x) - BW'(y);

  // operand select for the shared multiplier
  always_comb begin
    unique case (ctrl.opb_sel)
      apme_pkg::OPB_X:    opb = BW'(x);
      apme_pkg::OPB_D1:   opb = BW'(d1);
      apme_pkg::OPB_D2:   opb = BW'(d2);
      apme_pkg::OPB_FD1:  opb = BW'(fd1);
      apme_pkg::OPB_FD2:  opb = BW'(fd2);
      apme_pkg::OPB_DIFF: opb = xy_diff;
      default:            opb = '0;
    endcase
  end

  // biquad output, saturated to the feedback width
  assign acc_shr = trunc_shift(acc);

  always_comb begin
    if (acc_shr > Y_HI) begin
      y_sat = YW'(Y_HI);
    end else if (acc_shr < Y_LO) begin
      y_sat = YW'(Y_LO);
    end else begin
      y_sat = acc_shr[YW-1:0];
    end
  end

  // final mixed sample with clip flag
  always_comb begin
    if (acc_shr > O_HI) begin
      out_sample = SW'(O_HI);
      clipped    = 1'b1;
    end else if (acc_shr < O_LO) begin
      out_sample = SW'(O_LO);
      clipped    = 1'b1;
    end else begin
      out_sample = acc_shr[SW-1:0];
      clipped    = 1'b0;
    end
  end

  // product and accumulator
  always_ff @(posedge clk) begin
    prod <= coefs[ctrl.coef_sel] * opb;
    unique case (ctrl.acc_op)
      apme_pkg::ACC_HOLD: acc <= acc;
      apme_pkg::ACC_PROD: acc <= AW'(prod);
      apme_pkg::ACC_ADD:  acc <= acc + AW'(prod);
      apme_pkg::ACC_SUB:  acc <= acc - AW'(prod);
      apme_pkg::ACC_MIX:  acc <= AW'(xy_sum) <<< (apme_pkg::COEF_FRAC_BITS - 1);
      default:            acc <= acc;
    endcase
    if (load_x) begin
      x <= lr_sum[SW:1];
    end
    if (ctrl.y_load) begin
      y <= y_sat;
    end
  end

  // delay lines
  always_ff @(posedge clk) begin
    if (rst) begin
      d1  <= '0;
      d2  <= '0;
      fd1 <= '0;
      fd2 <= '0;
    end else if (ctrl.y_load) begin
      d2  <= d1;
      d1  <= x;
      fd2 <= fd1;
      fd1 <= y_sat;
    end
  end

endmodule

// ===== design/allpass_mix_peaking_eq.sv =====
// Mono peaking equalizer: each input word carries a stereo pair that is
// averaged to mono, run through a direct form 1 biquad with five
// programmable coefficients, and mixed back with the dry sample through
// mix_gain. A word is loaded into the output register at the last step
// of the microprogram, and the next input word is taken only when the
// sequencer returns to its first step, so no new word is accepted while
// one is in progress. The single shared coefficient multiplier is
// stepped by the microprogram through the six products, plus the
// accumulate, saturate and store steps. A result that waits on the
// output holds the sequencer at its last step. Coefficients are written
// through the cfg port, signed Q3.16; write them only while the block is
// idle. Indexes beyond mix_gain are ignored.
module allpass_mix_peaking_eq (
  input  logic                               clk,
  input  logic                               rst,
  // config write channel
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [apme_pkg::REG_IDX_W-1:0]     cfg_index,
  input  logic [apme_pkg::COEF_WIDTH-1:0]    cfg_data,
  // input stream
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [31:0]                        s_axis_tdata,  // left_sample, right_sample
  // output stream
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [15:0]                        m_axis_tdata,  // out_sample
  output logic [0:0]                         m_axis_tuser   // clipped
);

  localparam int SW = apme_pkg::SAMPLE_W;

  apme_pkg::coef_bank_t   coefs;
  apme_pkg::step_t        pc;
  apme_pkg::step_t        pc_next;
  apme_pkg::ctrl_t        ctrl;
  logic                   in_accept;
  logic                   slot_free;
  logic                   advance;
  logic                   store;
  logic signed [SW-1:0]   dp_sample;
  logic                   dp_clipped;

  // config registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      coefs[apme_pkg::REG_COEF_X0]  <= '0;
      coefs[apme_pkg::REG_COEF_X1]  <= '0;
      coefs[apme_pkg::REG_COEF_X2]  <= '0;
      coefs[apme_pkg::REG_COEF_Y1]  <= '0;
      coefs[apme_pkg::REG_COEF_Y2]  <= '0;
      coefs[apme_pkg::REG_MIX_GAIN] <= apme_pkg::MIX_GAIN_RESET;
    end else if (cfg_valid && cfg_index < apme_pkg::REG_IDX_W'(apme_pkg::NUM_REGS)) begin
      coefs[apme_pkg::reg_idx_t'(cfg_index)] <= cfg_data;
    end
  end

  // sequencer: fetch the control word and branch
  assign ctrl          = apme_pkg::PROGRAM[pc];
  assign s_axis_tready = (ctrl.jump == apme_pkg::JMP_WAIT_IN);
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign slot_free     = !m_axis_tvalid || m_axis_tready;

  always_comb begin
    unique case (ctrl.jump)
      apme_pkg::JMP_NEXT:     advance = 1'b1;
      apme_pkg::JMP_WAIT_IN:  advance = in_accept;
      apme_pkg::JMP_WAIT_OUT: advance = slot_free;
      default:                advance = 1'b1;
    endcase
    store   = (ctrl.jump == apme_pkg::JMP_WAIT_OUT) && slot_free;
    pc_next = advance ? ctrl.next_step : pc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= '0;
    end else begin
      pc <= pc_next;
    end
  end

  apme_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .ctrl         (ctrl),
    .coefs        (coefs),
    .load_x       (in_accept),
    .left_sample  (s_axis_tdata[15:0]),
    .right_sample (s_axis_tdata[31:16]),
    .out_sample   (dp_sample),
    .clipped      (dp_clipped)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (store) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (store) begin
      m_axis_tdata <= dp_sample;
      m_axis_tuser <= dp_clipped;
    end
  end

  // checks
  a_pc_range: assert property (@(posedge clk) disable iff (rst)
    pc < apme_pkg::STEP_W'(apme_pkg::NUM_STEPS))
    else $error("sequencer step out of program range");

  a_store_returns: assert property (@(posedge clk) disable iff (rst)
    store |=> (pc == '0) && m_axis_tvalid)
    else $error("result store did not return sequencer to idle");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    in_accept |-> ##11 m_axis_tvalid)
    else $error("no result word after accepted input");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> !s_axis_tready)
    else $error("input accepted while sequence in progress");

endmodule

// ===== verif/allpass_mix_peaking_eq_checker.sv =====
module allpass_mix_peaking_eq_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [apme_pkg::REG_IDX_W-1:0]  cfg_index,
  input  logic [apme_pkg::COEF_WIDTH-1:0] cfg_data,
  input  logic                            s_axis_tvalid,
  input  logic                            s_axis_tready,
  input  logic [31:0]                     s_axis_tdata,   // left_sample, right_sample
  input  logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  input  logic [15:0]                     m_axis_tdata,   // out_sample
  input  logic [0:0]                      m_axis_tuser,   // clipped
  output int                              errors,
  output int                              outstanding
);

  typedef struct packed {
    logic signed [apme_pkg::SAMPLE_W-1:0] out_sample;
    logic                                 clipped;
  } eq_word_t;

  // shadow of the coefficient bank and the filter history
  apme_pkg::coef_bank_t                 coefs;
  logic signed [apme_pkg::SAMPLE_W-1:0] in_d1, in_d2;
  logic signed [apme_pkg::Y_W-1:0]      fb_d1, fb_d2;
  eq_word_t                             expected_words [$];
  int                                   fails;

  // divide by 2^COEF_FRAC_BITS, truncating toward zero
  function automatic longint toward_zero(input longint v);
    if (v < 0) return -((-v) >>> apme_pkg::COEF_FRAC_BITS);
    return v >>> apme_pkg::COEF_FRAC_BITS;
  endfunction

  // one stereo pair in, one equalized mono word out; advances the history
  function automatic eq_word_t equalize(input logic signed [apme_pkg::SAMPLE_W-1:0] left,
                                        input logic signed [apme_pkg::SAMPLE_W-1:0] right);
    longint   mono, acc, filt, mix, scaled;
    eq_word_t res;
    // floor of half the 17-bit sum
    mono = (longint'(left) + longint'(right)) >>> 1;
    acc  = longint'(coefs[apme_pkg::REG_COEF_X0]) * mono
         + longint'(coefs[apme_pkg::REG_COEF_X1]) * longint'(in_d1)
         + longint'(coefs[apme_pkg::REG_COEF_X2]) * longint'(in_d2)
         - longint'(coefs[apme_pkg::REG_COEF_Y1]) * longint'(fb_d1)
         - longint'(coefs[apme_pkg::REG_COEF_Y2]) * longint'(fb_d2);
    filt = toward_zero(acc);
    if (filt > apme_pkg::Y_MAX) filt = apme_pkg::Y_MAX;
    else if (filt < apme_pkg::Y_MIN) filt = apme_pkg::Y_MIN;
    in_d2 = in_d1;
    in_d1 = mono[apme_pkg::SAMPLE_W-1:0];
    fb_d2 = fb_d1;
    fb_d1 = filt[apme_pkg::Y_W-1:0];
    // half the sum plus gain times the difference
    mix = (mono + filt) * (longint'(1) << (apme_pkg::COEF_FRAC_BITS - 1))
        + longint'(coefs[apme_pkg::REG_MIX_GAIN]) * (mono - filt);
    scaled = toward_zero(mix);
    res.clipped = (scaled > apme_pkg::OUT_MAX) || (scaled < apme_pkg::OUT_MIN);
    if (scaled > apme_pkg::OUT_MAX) scaled = apme_pkg::OUT_MAX;
    else if (scaled < apme_pkg::OUT_MIN) scaled = apme_pkg::OUT_MIN;
    res.out_sample = scaled[apme_pkg::SAMPLE_W-1:0];
    return res;
  endfunction

  // track register writes, predict on each input word, compare each output word
  always @(posedge clk) begin
    eq_word_t want;
    if (rst) begin
      for (int i = 0; i < apme_pkg::NUM_REGS; i++) coefs[i] = '0;
      coefs[apme_pkg::REG_MIX_GAIN] = apme_pkg::MIX_GAIN_RESET;
      in_d1 = '0;
      in_d2 = '0;
      fb_d1 = '0;
      fb_d2 = '0;
      expected_words.delete();
      fails = 0;
    end else begin
      if (cfg_valid && cfg_ready && cfg_index < apme_pkg::NUM_REGS)
        coefs[cfg_index] = apme_pkg::coef_t'(cfg_data);
      if (s_axis_tvalid && s_axis_tready)
        expected_words.push_back(equalize(s_axis_tdata[15:0], s_axis_tdata[31:16]));
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_words.size() == 0) begin
          $error("unexpected output word: out_sample %0d clipped %0d",
                 $signed(m_axis_tdata), m_axis_tuser[0]);
          fails++;
        end else begin
          want = expected_words.pop_front();
          if (m_axis_tdata !== want.out_sample) begin
            $error("out_sample: expected %0d, actual %0d",
                   want.out_sample, $signed(m_axis_tdata));
            fails++;
          end
          if (m_axis_tuser[0] !== want.clipped) begin
            $error("clipped: expected %0d, actual %0d", want.clipped, m_axis_tuser[0]);
            fails++;
          end
        end
      end
    end
    errors      <= fails;
    outstanding <= expected_words.size();
  end

endmodule

// ===== verif/allpass_mix_peaking_eq_tb.sv =====
module allpass_mix_peaking_eq_tb;

  localparam int ITEMS_PER_PHASE = 116;
  localparam int NUM_PHASES      = 8;

  localparam apme_pkg::coef_t COEF_MAX = {1'b0, {(apme_pkg::COEF_WIDTH-1){1'b1}}};
  localparam apme_pkg::coef_t COEF_MIN = {1'b1, {(apme_pkg::COEF_WIDTH-1){1'b0}}};

  // indexes past the register map
  localparam logic [apme_pkg::REG_IDX_W-1:0] IDX_UNMAPPED =
    apme_pkg::REG_IDX_W'(apme_pkg::NUM_REGS);
  localparam logic [apme_pkg::REG_IDX_W-1:0] IDX_TOP      = '1;

  // coefficient set kinds
  localparam int SET_MILD      = 0;
  localparam int SET_ALTERNATE = 1;
  localparam int SET_ALL_MAX   = 2;
  localparam int SET_ALL_MIN   = 3;
  localparam int SET_RAND_FULL = 4;
  localparam int SET_RAND_MOD  = 5;
  localparam int SET_DRY_ONLY  = 6;
  localparam int SET_DEFAULTS  = 7;

  logic                            clk;
  logic                            rst;
  logic                            cfg_valid;
  logic                            cfg_ready;
  logic [apme_pkg::REG_IDX_W-1:0]  cfg_index;
  logic [apme_pkg::COEF_WIDTH-1:0] cfg_data;
  logic                            s_axis_tvalid;
  logic                            s_axis_tready;
  logic [31:0]                     s_axis_tdata;   // left_sample, right_sample
  logic                            m_axis_tvalid;
  logic                            m_axis_tready;
  logic [15:0]                     m_axis_tdata;   // out_sample
  logic [0:0]                      m_axis_tuser;   // clipped

  int errors;
  int outstanding;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_cycles    = 0;

  allpass_mix_peaking_eq u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  allpass_mix_peaking_eq_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .errors       (errors),
    .outstanding  (outstanding)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // output side: random stalls, or a long hold-off when requested
  initial begin
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        m_axis_tready <= 1'b0;
        hold_cycles--;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // run limit
  initial begin
    #(12 * 600000);
    $display("[allpass_mix_peaking_eq] ERROR");
    $finish;
  end

  // mostly full-range, with extremes and small values mixed in
  function automatic logic signed [15:0] pick_sample();
    case ($urandom_range(9))
      0:       return 16'sh7fff;
      1:       return 16'sh8000;
      2, 3:    return 16'(int'($urandom_range(512)) - 256);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic apme_pkg::coef_bank_t pick_coefs(input int kind);
    apme_pkg::coef_bank_t bank;
    for (int i = 0; i < apme_pkg::NUM_REGS; i++) bank[i] = '0;
    case (kind)
      SET_MILD: begin
        bank[apme_pkg::REG_COEF_X0]  = 20'sd16384;
        bank[apme_pkg::REG_COEF_X1]  = -20'sd8192;
        bank[apme_pkg::REG_COEF_X2]  = 20'sd4096;
        bank[apme_pkg::REG_COEF_Y1]  = -20'sd32768;
        bank[apme_pkg::REG_COEF_Y2]  = 20'sd8192;
        bank[apme_pkg::REG_MIX_GAIN] = COEF_MIN;
      end
      SET_ALTERNATE: begin
        bank[apme_pkg::REG_COEF_X0]  = COEF_MAX;
        bank[apme_pkg::REG_COEF_X1]  = COEF_MIN;
        bank[apme_pkg::REG_COEF_X2]  = COEF_MAX;
        bank[apme_pkg::REG_COEF_Y1]  = COEF_MIN;
        bank[apme_pkg::REG_COEF_Y2]  = COEF_MAX;
        bank[apme_pkg::REG_MIX_GAIN] = COEF_MAX;
      end
      SET_ALL_MAX: for (int i = 0; i < apme_pkg::NUM_REGS; i++) bank[i] = COEF_MAX;
      SET_ALL_MIN: for (int i = 0; i < apme_pkg::NUM_REGS; i++) bank[i] = COEF_MIN;
      SET_RAND_FULL:
        for (int i = 0; i < apme_pkg::NUM_REGS; i++) bank[i] = apme_pkg::coef_t'($urandom);
      SET_RAND_MOD:
        for (int i = 0; i < apme_pkg::NUM_REGS; i++)
          bank[i] = apme_pkg::coef_t'(int'($urandom_range(131072)) - 65536);
      SET_DRY_ONLY: bank[apme_pkg::REG_MIX_GAIN] = apme_pkg::coef_t'($urandom);
      default: bank[apme_pkg::REG_MIX_GAIN] = apme_pkg::MIX_GAIN_RESET;
    endcase
    return bank;
  endfunction

  // one stereo pair, after a random idle stretch
  task automatic send_pair(input logic signed [15:0] left, input logic signed [15:0] right);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {right, left};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  // stop sending and let every pending word come out
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  // write the whole bank plus one stray index that must be ignored
  task automatic load_coefs(input apme_pkg::coef_bank_t bank,
                            input logic [apme_pkg::REG_IDX_W-1:0] stray);
    cfg_valid <= 1'b1;
    cfg_index <= stray;
    cfg_data  <= apme_pkg::coef_t'($urandom);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    for (int i = 0; i < apme_pkg::NUM_REGS; i++) begin
      cfg_index <= apme_pkg::reg_idx_t'(i);
      cfg_data  <= bank[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // stimulus and verdict
  initial begin
    rst           <= 1'b1;
    cfg_valid     <= 1'b0;
    cfg_index     <= '0;
    cfg_data      <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset coefficients: pass-through, sign and floor of the average
    send_pair(16'sd0, 16'sd0);
    send_pair(16'sh7fff, 16'sh7fff);
    send_pair(16'sh8000, 16'sh8000);
    send_pair(-16'sd1, 16'sd0);
    send_pair(16'sd1, 16'sd0);
    send_pair(16'sh7fff, 16'sh8000);
    drain();

    // extreme coefficients: biquad and output saturation both ways
    load_coefs(pick_coefs(SET_ALTERNATE), IDX_UNMAPPED);
    send_pair(16'sh7fff, 16'sh7fff);
    send_pair(16'sh8000, 16'sh8000);
    send_pair(16'sd12345, -16'sd321);
    send_pair(16'sh8000, 16'sh8000);
    send_pair(16'sd0, 16'sd0);
    send_pair(-16'sd1, -16'sd2);
    drain();

    // fractional coefficients, negative gain: truncation toward zero
    load_coefs(pick_coefs(SET_MILD), IDX_TOP);
    send_pair(-16'sd3, 16'sd0);
    send_pair(16'sd1000, -16'sd3001);
    send_pair(-16'sd7, -16'sd8);
    send_pair(16'sh7fff, 16'sd0);
    send_pair(16'sh8000, 16'sd1);
    send_pair(16'sd255, 16'sd256);
    drain();

    // random phases over coefficient sets and idling modes
    for (int p = 0; p < NUM_PHASES; p++) begin
      load_coefs(pick_coefs((p + 2) % NUM_PHASES), (p % 2 == 0) ? IDX_TOP : IDX_UNMAPPED);
      case (p % 4)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 86; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 86; end
        default: begin send_idle_pct = 17; recv_stall_pct = 17; end
      endcase
      // back-pressure: hold the output long enough to fill the block
      if (p == 0) hold_cycles = 300;
      for (int k = 0; k < ITEMS_PER_PHASE; k++)
        send_pair(pick_sample(), pick_sample());
      drain();
    end

    repeat (30) @(posedge clk);
    if (errors == 0 && outstanding == 0) begin
      $display("[allpass_mix_peaking_eq] OK");
    end else begin
      $display("[allpass_mix_peaking_eq] ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/apme_pkg.sv
design/apme_datapath.sv
design/allpass_mix_peaking_eq.sv
verif/allpass_mix_peaking_eq_checker.sv
verif/allpass_mix_peaking_eq_tb.sv
